@@ rtl/core/double_ended_queue_macros.svh @@
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Concurrent assertion on the rising clock edge, disabled while reset is low.
`define DEQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("deque check failed");

// Implication form: when ante holds, cons holds in the same cycle.
`define DEQ_ASSERT_IMP(lbl, ante, cons) \
  `DEQ_ASSERT(lbl, (ante) |-> (cons))

// Implication form: when ante holds, cons holds in the next cycle.
`define DEQ_ASSERT_NXT(lbl, ante, cons) \
  `DEQ_ASSERT(lbl, (ante) |=> (cons))

`endif

@@ rtl/core/deq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

  // Default number of slots in the ring store.
  localparam int DefaultDepth = 16;

  // Width of one stored word and of the reported occupancy.
  localparam int DataW = 32;
  localparam int OccW  = 5;

  // Operation codes carried by an incoming transaction.
  typedef enum logic [1:0] {
    ModePushFront = 2'd0,
    ModePushRear  = 2'd1,
    ModePopFront  = 2'd2,
    ModePopRear   = 2'd3
  } mode_e;

  // Status codes reported with each result.
  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StEmpty = 2'd1,
    StFull  = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic execute;
  } deq_cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/deq_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module deq_datapath #(
  parameter int DEPTH = deq_pkg::DefaultDepth
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire deq_pkg::deq_cmd_t                  cmd_i,
  input  wire logic [1:0]                         mode_i,
  input  wire logic signed [deq_pkg::DataW-1:0]   value_i,
  output logic signed [deq_pkg::DataW-1:0]        popped_o,
  output logic [1:0]                              status_o,
  output logic [deq_pkg::OccW-1:0]                occupancy_o
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int SumW = AW + 1;

  // Captured transaction.
  logic [1:0]                 mode_q;
  logic [deq_pkg::DataW-1:0]  value_q;

  // Queue pointers.
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;

  // Result registers.
  deq_pkg::status_e           status_q, status_d;
  logic                       pop_ok_q, pop_ok_d;
  logic [deq_pkg::DataW-1:0]  rd_data_q;

  // Ring store.
  logic [deq_pkg::DataW-1:0]  mem_q [DEPTH];
  logic                       mem_we, mem_re;
  logic [AW-1:0]              mem_addr;

  // Ring address arithmetic.
  logic [AW-1:0]   head_dec, head_inc, rear_free, rear_last;
  logic [SumW-1:0] free_sum, last_sum;
  logic [CW-1:0]   last_off;
  logic            is_full, is_empty;

  assign is_full  = (count_q == CW'(DEPTH));
  assign is_empty = (count_q == '0);

  assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - 1'b1;
  assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;

  // The sums stay below twice the depth, so one compare and subtract wraps them.
  assign last_off = count_q - 1'b1;
  assign free_sum = SumW'(head_q) + SumW'(count_q);
  assign last_sum = SumW'(head_q) + SumW'(last_off);
  assign rear_free = (free_sum >= SumW'(DEPTH)) ? AW'(free_sum - SumW'(DEPTH))
                                                 : AW'(free_sum);
  assign rear_last = (last_sum >= SumW'(DEPTH)) ? AW'(last_sum - SumW'(DEPTH))
                                                 : AW'(last_sum);

  // Decode the operation into at most one store access and the pointer update.
  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    status_d = deq_pkg::StOk;
    pop_ok_d = 1'b0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = head_q;
    unique case (deq_pkg::mode_e'(mode_q))
      deq_pkg::ModePushFront: begin
        if (is_full) begin
          status_d = deq_pkg::StFull;
        end else begin
          mem_we   = 1'b1;
          mem_addr = head_dec;
          head_d   = head_dec;
          count_d  = count_q + 1'b1;
        end
      end
      deq_pkg::ModePushRear: begin
        if (is_full) begin
          status_d = deq_pkg::StFull;
        end else begin
          mem_we   = 1'b1;
          mem_addr = rear_free;
          count_d  = count_q + 1'b1;
        end
      end
      deq_pkg::ModePopFront: begin
        if (is_empty) begin
          status_d = deq_pkg::StEmpty;
        end else begin
          mem_re   = 1'b1;
          pop_ok_d = 1'b1;
          mem_addr = head_q;
          head_d   = head_inc;
          count_d  = last_off;
        end
      end
      deq_pkg::ModePopRear: begin
        if (is_empty) begin
          status_d = deq_pkg::StEmpty;
        end else begin
          mem_re   = 1'b1;
          pop_ok_d = 1'b1;
          mem_addr = rear_last;
          count_d  = last_off;
        end
      end
      default: begin
        status_d = deq_pkg::StOk;
      end
    endcase
  end

  // Capture the incoming transaction.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q  <= mode_i;
      value_q <= value_i;
    end
  end

  // Pointer and status registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      count_q  <= '0;
      status_q <= deq_pkg::StOk;
      pop_ok_q <= 1'b0;
    end else if (cmd_i.execute) begin
      head_q   <= head_d;
      count_q  <= count_d;
      status_q <= status_d;
      pop_ok_q <= pop_ok_d;
    end
  end

  // Single-port store with registered read data.
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute && mem_we) begin
      mem_q[mem_addr] <= value_q;
    end
    if (cmd_i.execute && mem_re) begin
      rd_data_q <= mem_q[mem_addr];
    end
  end

  assign popped_o    = pop_ok_q ? $signed(rd_data_q) : '0;
  assign status_o    = status_q;
  assign occupancy_o = deq_pkg::OccW'(count_q);

endmodule

`default_nettype wire

@@ rtl/core/deq_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module deq_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  output logic                    done_o,
  output deq_pkg::deq_cmd_t       cmd_o
);

  typedef enum logic [1:0] {
    StIdle,
    StExec,
    StResp
  } state_e;

  state_e state_q;
  logic   done_q;

  // Sequence: accept, execute on the store, present the result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q  <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: begin
          done_q <= 1'b0;
          if (start) begin
            state_q <= StExec;
          end
        end
        StExec: begin
          state_q <= StResp;
          done_q  <= 1'b1;
        end
        StResp: begin
          state_q <= StIdle;
          done_q  <= 1'b0;
        end
        default: begin
          state_q <= StIdle;
          done_q  <= 1'b0;
        end
      endcase
    end
  end

  assign busy          = (state_q != StIdle);
  assign done_o        = done_q;
  assign cmd_o.capture = start && (state_q == StIdle);
  assign cmd_o.execute = (state_q == StExec);

endmodule

`default_nettype wire

@@ rtl/core/double_ended_queue.sv @@
// A transaction is captured when it is accepted, executed on the store in the
// execute state, and its result strobe rises as the block enters the response state.
// A new transaction is taken only once the block is idle again (accept, one access of the
// single store port, result); busy is high in the execute and response states.
// Each result is shown for one cycle on done_o; the receiver cannot stall.
// Reset clears the front pointer and the count; stored words stay undefined.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue #(
  parameter int DEPTH = deq_pkg::DefaultDepth
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [1:0]                        mode_i,
  input  wire logic signed [deq_pkg::DataW-1:0]  value_i,
  output logic                                   done_o,
  output logic signed [deq_pkg::DataW-1:0]       popped_o,
  output logic [1:0]                             status_o,
  output logic [deq_pkg::OccW-1:0]               occupancy_o
);

  deq_pkg::deq_cmd_t cmd;

  // Sequencing.
  deq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  // Store, pointers and result registers.
  deq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .mode_i      (mode_i),
    .value_i     (value_i),
    .popped_o    (popped_o),
    .status_o    (status_o),
    .occupancy_o (occupancy_o)
  );

endmodule

`default_nettype wire

@@ rtl/core/deq_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "double_ended_queue_macros.svh"

module deq_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              start,
  input wire logic                              busy,
  input wire logic                              done_o,
  input wire logic signed [deq_pkg::DataW-1:0]  popped_o,
  input wire logic [1:0]                        status_o,
  input wire logic [deq_pkg::OccW-1:0]          occupancy_o
);

  logic accept;
  assign accept = start && !busy;

  // Every accepted transaction yields its result once the controller has passed its execute state.
  `DEQ_ASSERT(a_resp_latency, accept |-> ##2 done_o)

  // A result ends the transaction and frees the block.
  `DEQ_ASSERT_NXT(a_idle_after_resp, done_o, !busy)

  // Failed operations never return a word.
  `DEQ_ASSERT_IMP(a_fail_no_word, done_o && (status_o != deq_pkg::StOk), popped_o == '0)

  // An empty report means nothing is stored.
  `DEQ_ASSERT_IMP(a_empty_count, done_o && (status_o == deq_pkg::StEmpty), occupancy_o == '0)

endmodule

bind double_ended_queue deq_checker u_deq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .done_o      (done_o),
  .popped_o    (popped_o),
  .status_o    (status_o),
  .occupancy_o (occupancy_o)
);

`default_nettype wire

@@ dv/double_ended_queue_tb.sv @@
`timescale 1ns / 1ps

module double_ended_queue_tb;
  import deq_pkg::*;

  localparam int Depth = DefaultDepth;
  localparam int RandomOps = 1350;

  // One expected result of a deque transaction.
  typedef struct {
    logic [DataW-1:0] popped;
    status_e          status;
    logic [OccW-1:0]  occupancy;
  } deq_outcome_t;

  // Shadow copy of the ring store that predicts every result and checks it
  // against what the block reports.
  class deque_mirror;
    logic [DataW-1:0] slots [Depth];
    int unsigned      head = 0;
    int unsigned      count = 0;
    deq_outcome_t     outcomes_due [$];
    int               mismatches = 0;

    // Apply one accepted transaction to the shadow state.
    function void note_op(mode_e op, logic [DataW-1:0] word);
      deq_outcome_t r;
      r.popped = '0;
      r.status = StOk;
      if (op == ModePushFront || op == ModePushRear) begin
        if (count >= Depth) begin
          r.status = StFull;
        end else if (op == ModePushFront) begin
          head = (head + Depth - 1) % Depth;
          slots[head] = word;
          count++;
        end else begin
          slots[(head + count) % Depth] = word;
          count++;
        end
      end else begin
        if (count == 0) begin
          r.status = StEmpty;
        end else if (op == ModePopFront) begin
          r.popped = slots[head];
          head = (head + 1) % Depth;
          count--;
        end else begin
          r.popped = slots[(head + count - 1) % Depth];
          count--;
        end
      end
      r.occupancy = OccW'(count);
      outcomes_due.push_back(r);
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    // Compare one reported result with the oldest prediction.
    function void check_result(logic [DataW-1:0] popped, logic [1:0] status,
                               logic [OccW-1:0] occupancy);
      deq_outcome_t want;
      if (outcomes_due.size() == 0) begin
        report($sformatf("result with no transaction waiting: popped %h status %0d occ %0d",
                         popped, status, occupancy));
        return;
      end
      want = outcomes_due.pop_front();
      if (popped !== want.popped)
        report($sformatf("popped expected %h actual %h", want.popped, popped));
      if (status !== want.status)
        report($sformatf("status expected %0d actual %0d", want.status, status));
      if (occupancy !== want.occupancy)
        report($sformatf("occupancy expected %0d actual %0d", want.occupancy, occupancy));
    endfunction

    function int pending();
      return outcomes_due.size();
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [1:0]              mode_i = ModePushFront;
  logic signed [DataW-1:0] value_i = '0;
  logic                    done_o;
  logic signed [DataW-1:0] popped_o;
  logic [1:0]              status_o;
  logic [OccW-1:0]         occupancy_o;

  deque_mirror mirror = new;

  double_ended_queue #(.DEPTH(Depth)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .mode_i      (mode_i),
    .value_i     (value_i),
    .done_o      (done_o),
    .popped_o    (popped_o),
    .status_o    (status_o),
    .occupancy_o (occupancy_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Watch both sides of the block at each rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) mirror.note_op(mode_e'(mode_i), value_i);
      if (done_o) mirror.check_result(popped_o, status_o, occupancy_o);
    end
  end

  // Offer one transaction after an optional idle gap and wait until the block is no longer busy.
  task automatic issue_op(input mode_e op, input logic [DataW-1:0] word, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start   <= 1'b1;
    mode_i  <= op;
    value_i <= word;
    do @(posedge clk_i); while (busy);
  endtask

  // Hold off new transactions until every predicted result has been seen.
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (mirror.pending() != 0);
  endtask

  // Mostly random words, with the corner values showing up often.
  function automatic logic [DataW-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int    sent;
    int    blk_left;
    int    push_pct;
    bit    no_gaps;
    bit    drained_once;
    mode_e op;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Pops on an empty queue, then the extreme words in and out of both ends.
    // The final front pop takes the last element and moves the front pointer on.
    issue_op(ModePopFront, 32'h1234_5678, 0);
    issue_op(ModePopRear, 32'hdead_beef, 0);
    issue_op(ModePushRear, 32'h7fff_ffff, 0);
    issue_op(ModePushFront, 32'h8000_0000, 3);
    issue_op(ModePopRear, 32'h0, 0);
    issue_op(ModePopFront, 32'h0, 1);

    // Fill from both ends until full, then try one push at each end.
    for (int i = 0; i < Depth; i++)
      issue_op(i[0] ? ModePushRear : ModePushFront, pick_word(), 0);
    issue_op(ModePushFront, 32'hffff_ffff, 0);
    issue_op(ModePushRear, 32'h0000_0001, 2);

    // Random part: blocks that lean toward pushes or pops so the occupancy
    // swings between empty and full, with and without idle gaps.
    sent = 0;
    blk_left = 0;
    push_pct = 50;
    no_gaps = 1'b0;
    drained_once = 1'b0;
    while (sent < RandomOps) begin
      if (blk_left == 0) begin
        blk_left = $urandom_range(10, 60);
        case ($urandom_range(0, 2))
          0: push_pct = 85;
          1: push_pct = 50;
          default: push_pct = 15;
        endcase
        no_gaps = ($urandom_range(0, 2) == 0);
      end
      if (!drained_once && sent >= RandomOps / 2) begin
        wait_drained();
        drained_once = 1'b1;
      end
      if ($urandom_range(0, 99) < push_pct)
        op = $urandom_range(0, 1) ? ModePushRear : ModePushFront;
      else
        op = $urandom_range(0, 1) ? ModePopRear : ModePopFront;
      issue_op(op, pick_word(), no_gaps ? 0 : $urandom_range(0, 11));
      sent++;
      blk_left--;
    end

    // Let the last results come back, then watch a little longer for strays.
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mirror.mismatches == 0 && mirror.pending() == 0) begin
      $display("double_ended_queue_tb passed");
    end else begin
      $display("double_ended_queue_tb failed");
    end
    $finish;
  end

  // Guard against a hang anywhere in the run.
  initial begin
    #400000;
    $display("double_ended_queue_tb failed");
    $finish;
  end

endmodule
